// ===== rtl/bse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, types and helpers for the bucket sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int MaxItems   = 4096;
   localparam int ValueSpan  = 1024;
   localparam int MaxBuckets = 16;

   localparam int AddrW  = $clog2(MaxItems);
   localparam int CountW = $clog2(MaxItems + 1);
   localparam int ValW   = 10;
   localparam int BktW   = 4;
   localparam int CfgW   = 5;
   localparam int EntW   = BktW + ValW;
   localparam int SpanW  = $clog2(ValueSpan + 1);

   typedef logic [1:0] mode_type;
   localparam mode_type ModeLoad   = 2'd0;
   localparam mode_type ModeFinish = 2'd1;
   localparam mode_type ModeFetch  = 2'd2;

   typedef logic [ValW-1:0]   value_type;
   typedef logic [BktW-1:0]   bucket_type;
   typedef logic [AddrW-1:0]  addr_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [EntW-1:0]   entry_type;   // {bucket, value}: compare as key
   typedef logic [SpanW-1:0]  span_type;

   // bucket width for each effective count, one entry per count 0..MaxBuckets
   localparam logic [MaxBuckets:0][SpanW-1:0] BucketWidth = {
      span_type'(ValueSpan / 16), span_type'(ValueSpan / 15),
      span_type'(ValueSpan / 14), span_type'(ValueSpan / 13),
      span_type'(ValueSpan / 12), span_type'(ValueSpan / 11),
      span_type'(ValueSpan / 10), span_type'(ValueSpan / 9),
      span_type'(ValueSpan / 8),  span_type'(ValueSpan / 7),
      span_type'(ValueSpan / 6),  span_type'(ValueSpan / 5),
      span_type'(ValueSpan / 4),  span_type'(ValueSpan / 3),
      span_type'(ValueSpan / 2),  span_type'(ValueSpan / 1),
      span_type'(1)
   };

   // bucket lookup per (count, value): each count reduces to a compare table
   function automatic bucket_type bucket_of(logic [CfgW-1:0] cnt, value_type v);
      int c;
      int w;
      int b;
      c = (cnt == '0) ? 1 : int'(cnt);
      if (c > MaxBuckets) c = MaxBuckets;
      w = int'(BucketWidth[c]);
      if (w == 0) w = 1;
      if (v == '0) begin
         b = 0;
      end else begin
         b = 0;
         for (int k = 1; k < MaxBuckets; k++) begin
            if (k < c && int'(v) - 1 >= k * w) b = k;
         end
      end
      return bucket_type'(b);
   endfunction

endpackage

// ===== rtl/bse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== rtl/bucket_sort_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_sort_engine_core
// Bucket sort engine: load values, sort by (bucket, value), fetch in order.
// ----------------------------------------------------------------------------
// Load beats file a value and its bucket into a 4096-entry single-port store.
// A finish beat bubble-sorts the store by (bucket, value) with one shared
// compare unit walking the single RAM port: each adjacent pair takes a read,
// a read and a compare, plus a write state on a swap, whose first write rides
// the compare state; sorting ends early once a pass sees no swap. A fetch
// beat reads one entry through StFetch and StFRet and returns it from the
// output register. The block stalls the request side while busy, and also
// while a result waits in the output register; a new request is taken once
// that result leaves, on the same edge at earliest.
// ----------------------------------------------------------------------------
module bucket_sort_engine_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bse_pkg::mode_type     req_mode,
   input  bse_pkg::value_type    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bse_pkg::value_type    rsp_sorted_value,
   output bse_pkg::bucket_type   rsp_bucket_index,
   output logic                  rsp_last_value,
   output logic                  rsp_none_left,
   output logic                  rsp_dropped_any,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [4:0]            csr_bucket_count
);
   import bse_pkg::*;

   typedef enum logic [6:0] {
      StIdle  = 7'b0000001,
      StFetch = 7'b0000010,
      StRdA   = 7'b0000100,
      StRdB   = 7'b0001000,
      StCmp   = 7'b0010000,
      StWrA   = 7'b0100000,
      StFRet  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [CfgW-1:0] cnt_ff;
   count_type  loaded_ff, loaded_in;
   count_type  fpos_ff, fpos_in;
   logic       ovf_ff, ovf_in, sorted_ff, sorted_in;
   addr_type   idx_ff, idx_in;      // pair index i in the pass
   count_type  end_ff, end_in;      // pass end
   logic       swp_ff, swp_in;
   entry_type  a_ff, a_in;
   logic       last_ff, last_in;

   logic       ram_we;
   addr_type   ram_addr;
   entry_type  ram_wd, ram_rd;

   logic       out_v_ff, out_v_in;
   value_type  o_val_ff, o_val_in;
   bucket_type o_bkt_ff, o_bkt_in;
   logic       o_last_ff, o_last_in, o_none_ff, o_none_in, o_drop_ff, o_drop_in;

   logic take;
   logic out_free;

   bse_ram #(.Width(EntW), .Depth(MaxItems)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign out_free  = !out_v_ff || !rsp_stall;
   // accept only from idle with a free result slot
   assign req_stall = !(state_ff == StIdle) || !out_free;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff; loaded_in = loaded_ff; fpos_in = fpos_ff;
      ovf_in = ovf_ff; sorted_in = sorted_ff; idx_in = idx_ff; end_in = end_ff;
      swp_in = swp_ff; a_in = a_ff; last_in = last_ff;
      ram_we = 1'b0; ram_addr = idx_ff; ram_wd = a_ff;
      out_v_in = out_v_ff && rsp_stall;
      o_val_in = o_val_ff; o_bkt_in = o_bkt_ff; o_last_in = o_last_ff;
      o_none_in = o_none_ff; o_drop_in = o_drop_ff;
      unique case (state_ff)
         StIdle: begin
            if (take) begin
               unique case (req_mode)
                  ModeLoad: begin
                     sorted_in = 1'b0; fpos_in = '0;
                     if (loaded_ff >= count_type'(MaxItems)) begin
                        ovf_in = 1'b1;
                     end else begin
                        ram_we = 1'b1;
                        ram_addr = addr_type'(loaded_ff);
                        ram_wd = {bucket_of(cnt_ff, req_value), req_value};
                        loaded_in = loaded_ff + 1'b1;
                     end
                  end
                  ModeFinish: begin
                     sorted_in = 1'b1; fpos_in = '0;
                     idx_in = '0; end_in = loaded_ff; swp_in = 1'b0;
                     if (loaded_ff >= count_type'(2)) state_in = StRdA;
                  end
                  ModeFetch: begin
                     if (sorted_ff && fpos_ff < loaded_ff) begin
                        ram_addr = addr_type'(fpos_ff);
                        last_in = (fpos_ff + 1'b1 == loaded_ff);
                        fpos_in = fpos_ff + 1'b1;
                        state_in = StFetch;
                     end else begin
                        out_v_in = 1'b1; o_val_in = '0; o_bkt_in = '0;
                        o_last_in = 1'b0; o_none_in = 1'b1; o_drop_in = ovf_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         StFetch: begin
            // hold the read on this beat's entry while the data lands
            ram_addr = addr_type'(fpos_ff - 1'b1);
            state_in = StFRet;
         end
         StFRet: begin
            out_v_in = 1'b1; o_val_in = ram_rd[ValW-1:0];
            o_bkt_in = ram_rd[EntW-1:ValW]; o_last_in = last_ff;
            o_none_in = 1'b0; o_drop_in = ovf_ff;
            state_in = StIdle;
         end
         StRdA: begin
            ram_addr = idx_ff; state_in = StRdB;
         end
         StRdB: begin
            ram_addr = idx_ff + 1'b1; state_in = StCmp;
         end
         StCmp: begin
            // a arrived last cycle via a_ff capture below; b arrives now
            if (a_ff > ram_rd) begin
               ram_we = 1'b1; ram_addr = idx_ff; ram_wd = ram_rd;
               swp_in = 1'b1;
               state_in = StWrA;
            end else begin
               a_in = ram_rd;
               if (count_type'(idx_ff) + 2'd2 >= end_ff) begin
                  end_in = end_ff - 1'b1; idx_in = '0; swp_in = 1'b0;
                  state_in = (swp_ff && end_ff > count_type'(2)) ? StRdA : StIdle;
               end else begin
                  idx_in = idx_ff + 1'b1; state_in = StRdA;
               end
            end
         end
         StWrA: begin
            ram_we = 1'b1; ram_addr = idx_ff + 1'b1; ram_wd = a_ff;
            if (count_type'(idx_ff) + 2'd2 >= end_ff) begin
               end_in = end_ff - 1'b1; idx_in = '0; swp_in = 1'b0;
               state_in = (end_ff > count_type'(2)) ? StRdA : StIdle;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = StRdA;
            end
         end
         default: state_in = StIdle;
      endcase
      // capture the first operand of the pair as it comes back
      if (state_ff == StRdB) a_in = ram_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; cnt_ff <= 5'd4; loaded_ff <= '0; fpos_ff <= '0;
         ovf_ff <= 1'b0; sorted_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; loaded_ff <= loaded_in; fpos_ff <= fpos_in;
         ovf_ff <= ovf_in; sorted_ff <= sorted_in; out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) cnt_ff <= csr_bucket_count;
      end
      idx_ff <= idx_in; end_ff <= end_in; swp_ff <= swp_in;
      a_ff <= a_in; last_ff <= last_in;
      o_val_ff <= o_val_in; o_bkt_ff <= o_bkt_in; o_last_ff <= o_last_in;
      o_none_ff <= o_none_in; o_drop_ff <= o_drop_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_sorted_value = o_val_ff;
   assign rsp_bucket_index = o_bkt_ff;
   assign rsp_last_value   = o_last_ff;
   assign rsp_none_left    = o_none_ff;
   assign rsp_dropped_any  = o_drop_ff;

   // never accept while sorting or fetching
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == StIdle) |-> req_stall) else $error("accept while busy");
   // overflow flag is sticky
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff) else $error("overflow flag cleared");
   // store never overfills
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= count_type'(MaxItems)) else $error("store overfilled");
   // none_left result carries zero payload
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_left |-> rsp_sorted_value == '0 && !rsp_last_value)
      else $error("none_left with payload");
endmodule

// ===== tb/sv/bucket_sort_engine_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_sort_engine_core_test
// Self-checking bench for the bucket sort engine core.
// ----------------------------------------------------------------------------
// Drives load, finish and fetch beats while a scoreboard keeps its own copy of
// the store and of the bucket count. Each fetch beat it accepts gets an
// expected answer. Each answer beat from the block is checked against the
// oldest expected answer. The bucket count is rewritten between rounds, and
// sometimes in the middle of a load run. Sender idle and receiver stall rates
// change from round to round.
// ----------------------------------------------------------------------------
module bucket_sort_engine_core_test;
   import bse_pkg::*;

   localparam mode_type ModeIgnored = 2'd3;
   localparam longint   CycleLimit  = 20_000_000;
   localparam int       LoadCap     = 104;   // keep sorts short

   typedef struct {
      value_type  sorted_value;
      bucket_type bucket_index;
      logic       last_value;
      logic       none_left;
      logic       dropped_any;
   } answer_type;

   // Model of the store plus the queue of answers still owed by the block.
   class sort_scoreboard;
      entry_type  store[$];
      answer_type owed[$];
      logic [CfgW-1:0] cnt = 5'd4;
      bit  sorted_now;
      bit  overflow;
      int  fetch_pos;
      int  errors;

      function bucket_type bucket_for(value_type v);
         int c;
         int w;
         int b;
         c = (cnt == 0) ? 1 : int'(cnt);
         if (c > MaxBuckets) c = MaxBuckets;
         w = ValueSpan / c;
         if (w == 0) w = 1;
         if (v == 0) return '0;
         b = (int'(v) - 1) / w;
         if (b > c - 1) b = c - 1;
         return bucket_type'(b);
      endfunction

      // Order the store by {bucket, value}; equal keys are identical entries.
      function void sort_store();
         entry_type e;
         int j;
         for (int i = 1; i < store.size(); i++) begin
            e = store[i];
            j = i - 1;
            while (j >= 0 && store[j] > e) begin
               store[j+1] = store[j];
               j--;
            end
            store[j+1] = e;
         end
      endfunction

      function void note_request(mode_type m, value_type v);
         answer_type a;
         case (m)
            ModeLoad: begin
               sorted_now = 0;
               fetch_pos  = 0;
               if (store.size() >= MaxItems) overflow = 1;
               else store.push_back({bucket_for(v), v});
            end
            ModeFinish: begin
               sort_store();
               sorted_now = 1;
               fetch_pos  = 0;
            end
            ModeFetch: begin
               a.dropped_any = overflow;
               if (sorted_now && fetch_pos < store.size()) begin
                  a.sorted_value = store[fetch_pos][ValW-1:0];
                  a.bucket_index = store[fetch_pos][EntW-1:ValW];
                  a.last_value   = (fetch_pos + 1 == store.size());
                  a.none_left    = 0;
                  fetch_pos++;
               end else begin
                  a.sorted_value = '0;
                  a.bucket_index = '0;
                  a.last_value   = 0;
                  a.none_left    = 1;
               end
               owed.push_back(a);
            end
            default: ;
         endcase
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected answer value=%0d bucket=%0d", $time,
                     got.sorted_value, got.bucket_index);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time,
                     want.sorted_value, got.sorted_value);
            errors++;
         end
         if (got.bucket_index !== want.bucket_index) begin
            $display("%0t: bucket_index expected %0d actual %0d", $time,
                     want.bucket_index, got.bucket_index);
            errors++;
         end
         if (got.last_value !== want.last_value) begin
            $display("%0t: last_value expected %0d actual %0d", $time,
                     want.last_value, got.last_value);
            errors++;
         end
         if (got.none_left !== want.none_left) begin
            $display("%0t: none_left expected %0d actual %0d", $time,
                     want.none_left, got.none_left);
            errors++;
         end
         if (got.dropped_any !== want.dropped_any) begin
            $display("%0t: dropped_any expected %0d actual %0d", $time,
                     want.dropped_any, got.dropped_any);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   mode_type  req_mode = ModeLoad;
   value_type req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   value_type  rsp_sorted_value;
   bucket_type rsp_bucket_index;
   logic rsp_last_value;
   logic rsp_none_left;
   logic rsp_dropped_any;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CfgW-1:0] csr_bucket_count = '0;

   sort_scoreboard sb;
   int     send_idle_pct;
   int     rsp_stall_pct;
   longint cycles;

   bucket_sort_engine_core dut (.*);

   always #1 clock = ~clock;

   // Kill a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("bucket_sort_engine_core test failed");
         $finish;
      end
   end

   // Receiver: pick the stall for the next edge at the falling edge.
   always @(negedge clock) begin
      if (!reset) rsp_stall = ($urandom_range(99) < rsp_stall_pct);
   end

   // Check every answer beat taken at the rising edge.
   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.sorted_value = rsp_sorted_value;
         got.bucket_index = rsp_bucket_index;
         got.last_value   = rsp_last_value;
         got.none_left    = rsp_none_left;
         got.dropped_any  = rsp_dropped_any;
         sb.check_answer(got);
      end
   end

   // Offer one request beat, hold it through stalls, and leave valid low.
   task automatic send_req(mode_type m, value_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_mode  = m;
      req_value = v;
      do @(posedge clock); while (req_stall);
      sb.note_request(m, v);
      @(negedge clock);
      req_valid = 0;
   endtask

   // Hold off until every owed answer is in, then let the block settle.
   task automatic drain();
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // Write the bucket count; call only while the block is idle.
   task automatic write_count(logic [CfgW-1:0] c);
      csr_valid        = 1;
      csr_bucket_count = c;
      do @(posedge clock); while (!csr_ready);
      sb.cnt = c;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_run(int n);
      for (int i = 0; i < n; i++) begin
         if (sb.store.size() >= LoadCap) return;
         send_req(ModeLoad, value_type'($urandom_range(1023)));
      end
   endtask

   initial begin
      logic [CfgW-1:0] counts[5];
      int n;
      counts = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17};
      sb = new();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: fetch before any finish, range extremes, bucket edges at
      // the reset count of four, an ignored mode, fetch past the end, and a
      // repeated finish that restarts fetching.
      send_req(ModeFetch, '0);
      send_req(ModeLoad, 10'd0);
      send_req(ModeLoad, 10'd1023);
      send_req(ModeLoad, 10'd1);
      send_req(ModeLoad, 10'd256);
      send_req(ModeLoad, 10'd257);
      send_req(ModeLoad, 10'd512);
      send_req(ModeLoad, 10'd768);
      send_req(ModeLoad, 10'd769);
      send_req(ModeIgnored, 10'h3FF);
      send_req(ModeFinish, '0);
      repeat (9) send_req(ModeFetch, '0);
      send_req(ModeFinish, '0);
      send_req(ModeFetch, '0);
      drain();

      // Random rounds, each with its own idle mix and bucket count.
      for (int r = 0; r < 28; r++) begin
         case (r % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         write_count((r < 5) ? counts[r] : CfgW'($urandom_range(31)));
         n = $urandom_range(7, 1);
         load_run(n / 2 + 1);
         if (r % 3 == 0) begin
            // Change the count mid-load: stored buckets must stay put.
            drain();
            write_count(CfgW'($urandom_range(31)));
         end
         if ($urandom_range(3) == 0) send_req(ModeFetch, '0);
         if ($urandom_range(3) == 0) send_req(ModeIgnored, value_type'($urandom));
         load_run(n - n / 2);
         send_req(ModeFinish, '0);
         if ($urandom_range(2) == 0) begin
            // Partial fetch, then a load resumes loading.
            repeat ($urandom_range(5)) send_req(ModeFetch, '0);
            send_req(ModeLoad, value_type'($urandom_range(1023)));
            send_req(ModeFetch, '0);
            send_req(ModeFinish, '0);
         end
         n = sb.store.size() + 1 + $urandom_range(1);
         for (int i = 0; i < n; i++) begin
            send_req(ModeFetch, '0);
            if ($urandom_range(40) == 0) send_req(ModeIgnored, '0);
         end
         drain();
      end

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("bucket_sort_engine_core test passed");
      end else begin
         $display("bucket_sort_engine_core test failed");
      end
      $finish;
   end

endmodule
